// ===== design/one_wire_bus_master_unit_defines.svh =====
// Assertion macros for the one-wire bus master unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OWBM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("owbm assertion failed");
`define OWBM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("owbm assertion failed");
`else
`define OWBM_ASSERT(label, clk, rst, prop)
`define OWBM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== design/owbm_pkg.sv =====
// Package for the one-wire bus master unit: widths, timer size, opcodes,
// register indexes and the result word layout. No dependencies.
package owbm_pkg;

  localparam int TIMER_BITS = 10;
  localparam int TIMER_MAX  = (1 << TIMER_BITS) - 1;

  localparam int LEN_W      = 10;   // widest timing register
  localparam int SLOT_W     = 7;    // slot timing registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd7;

  // result word, lowest field last
  typedef struct packed {
    logic       presence;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// ===== design/one_wire_bus_master_unit.sv =====
// One-wire bus master unit: top level, bus timing sequencer and output buffer.
// Depends on owbm_pkg and one_wire_bus_master_unit_defines.svh.
`include "one_wire_bus_master_unit_defines.svh"

// Each input word is one microsecond tick of the bus and yields exactly one result
// word. The whole tick (command start, slot timer, bit shifting and line sampling)
// is one combinational update of the sequencer registers, so a word is taken on every
// clock cycle while s_axis_tready is high; its result is registered into a two-entry
// output buffer. The slave side stays ready while at least one entry is free, so one
// stalled result does not stop input. The user must write the timing registers through
// the cfg port only while no command runs; the block itself does not enforce this.
// Commands: reset with presence detect, write byte, read byte, LSB first.
module one_wire_bus_master_unit
  import owbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] write_byte, [8] line_in, [15:9] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] cmd_valid, [2:1] opcode
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_byte, [11] presence,
  // [15:12] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
    PH_WR_LOW, PH_WR_HIGH,
    PH_RD_LOW, PH_RD_WAIT, PH_RD_REST
  } phase_t;

  // timing registers
  logic [LEN_W-1:0]  reset_low_us, presence_wait_us, reset_recovery_us;
  logic [SLOT_W-1:0] write_one_low_us, write_zero_low_us, write_slot_us;
  logic [SLOT_W-1:0] read_low_us, read_sample_us;

  // sequencer state
  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] tick_count, tick_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  presence_flag, presence_flag_next;
  logic [7:0]            read_result, read_result_next;

  // output buffer
  result_t out0, out1, res;
  logic    valid0, valid1;

  logic       cmd_valid, line_in;
  logic [1:0] opcode;
  logic [7:0] write_byte;
  logic       accept, pop;

  assign cmd_valid  = s_axis_tuser[0];
  assign opcode     = s_axis_tuser[2:1];
  assign write_byte = s_axis_tdata[7:0];
  assign line_in    = s_axis_tdata[8];

  assign s_axis_tready = !valid1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = valid0;
  assign pop           = valid0 && m_axis_tready;
  assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out0};

  // timer load for entering phase p; cur is the bit being sent
  function automatic logic [TIMER_BITS-1:0] phase_load(input phase_t p, input logic cur);
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  load;
    logic [SLOT_W-1:0] wr_low;
    logic [SLOT_W:0]   rd_low;
    wr_low = cur ? write_one_low_us : write_zero_low_us;
    rd_low = {1'b0, read_low_us} + {1'b0, read_sample_us};
    unique case (p)
      PH_RST_LOW:  len = reset_low_us;
      PH_RST_WAIT: len = presence_wait_us;
      PH_RST_REC:  len = reset_recovery_us;
      PH_WR_LOW:   len = LEN_W'(wr_low);
      PH_WR_HIGH:  len = (write_slot_us > wr_low) ? LEN_W'(write_slot_us - wr_low) : '0;
      PH_RD_LOW:   len = LEN_W'(read_low_us);
      PH_RD_WAIT:  len = LEN_W'(read_sample_us);
      PH_RD_REST:  len = ({1'b0, write_slot_us} > rd_low)
                         ? LEN_W'({1'b0, write_slot_us} - rd_low) : '0;
      default:     len = '0;
    endcase
    load = (len == '0) ? '0 : len - LEN_W'(1);
    if (int'(load) > TIMER_MAX) begin
      return TIMER_BITS'(TIMER_MAX);
    end
    return TIMER_BITS'(load);
  endfunction

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    read_result_next   = read_result;
    res                = '0;

    // a command starts on the tick it is taken
    if (phase == PH_IDLE && cmd_valid &&
        (opcode == OP_RESET || opcode == OP_WRITE || opcode == OP_READ)) begin
      bit_index_next  = '0;
      shift_byte_next = (opcode == OP_WRITE) ? write_byte : '0;
      if (opcode == OP_RESET) begin
        phase_next = PH_RST_LOW;
      end else if (opcode == OP_WRITE) begin
        phase_next = PH_WR_LOW;
      end else begin
        phase_next = PH_RD_LOW;
      end
      tick_count_next = phase_load(phase_next, shift_byte_next[0]);
    end

    if (phase_next != PH_IDLE) begin
      res.busy_res  = 1'b1;
      res.drive_low = (phase_next == PH_RST_LOW || phase_next == PH_WR_LOW ||
                       phase_next == PH_RD_LOW);
      if (tick_count_next != '0) begin
        tick_count_next = tick_count_next - TIMER_BITS'(1);
      end else begin
        unique case (phase_next)
          PH_RST_LOW: begin
            phase_next      = PH_RST_WAIT;
            tick_count_next = phase_load(PH_RST_WAIT, 1'b0);
          end
          PH_RST_WAIT: begin
            presence_flag_next = !line_in;
            phase_next         = PH_RST_REC;
            tick_count_next    = phase_load(PH_RST_REC, 1'b0);
          end
          PH_RST_REC: begin
            res.done_res = 1'b1;
            phase_next   = PH_IDLE;
          end
          PH_WR_LOW: begin
            phase_next      = PH_WR_HIGH;
            tick_count_next = phase_load(PH_WR_HIGH, shift_byte_next[bit_index_next]);
          end
          PH_WR_HIGH: begin
            if (bit_index_next == 3'd7) begin
              res.done_res = 1'b1;
              phase_next   = PH_IDLE;
            end else begin
              bit_index_next  = bit_index_next + 3'd1;
              phase_next      = PH_WR_LOW;
              tick_count_next = phase_load(PH_WR_LOW, shift_byte_next[bit_index_next]);
            end
          end
          PH_RD_LOW: begin
            phase_next      = PH_RD_WAIT;
            tick_count_next = phase_load(PH_RD_WAIT, 1'b0);
          end
          PH_RD_WAIT: begin
            if (line_in) begin
              shift_byte_next[bit_index_next] = 1'b1;
            end
            phase_next      = PH_RD_REST;
            tick_count_next = phase_load(PH_RD_REST, 1'b0);
          end
          PH_RD_REST: begin
            if (bit_index_next == 3'd7) begin
              read_result_next = shift_byte_next;
              res.done_res     = 1'b1;
              phase_next       = PH_IDLE;
            end else begin
              bit_index_next  = bit_index_next + 3'd1;
              phase_next      = PH_RD_LOW;
              tick_count_next = phase_load(PH_RD_LOW, 1'b0);
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    res.read_byte = read_result_next;
    res.presence  = presence_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us      <= LEN_W'(500);
      presence_wait_us  <= LEN_W'(80);
      reset_recovery_us <= LEN_W'(300);
      write_one_low_us  <= SLOT_W'(5);
      write_zero_low_us <= SLOT_W'(62);
      write_slot_us     <= SLOT_W'(65);
      read_low_us       <= SLOT_W'(4);
      read_sample_us    <= SLOT_W'(9);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RESET_LOW:      reset_low_us      <= cfg_data;
        REG_PRESENCE_WAIT:  presence_wait_us  <= cfg_data;
        REG_RESET_RECOVERY: reset_recovery_us <= cfg_data;
        REG_WRITE_ONE_LOW:  write_one_low_us  <= cfg_data[SLOT_W-1:0];
        REG_WRITE_ZERO_LOW: write_zero_low_us <= cfg_data[SLOT_W-1:0];
        REG_WRITE_SLOT:     write_slot_us     <= cfg_data[SLOT_W-1:0];
        REG_READ_LOW:       read_low_us       <= cfg_data[SLOT_W-1:0];
        REG_READ_SAMPLE:    read_sample_us    <= cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      read_result   <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      read_result   <= read_result_next;
    end
  end

  // two-entry output buffer, out0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      if (pop && accept) begin
        if (valid1) begin
          out0 <= out1;
          out1 <= res;
        end else begin
          out0 <= res;
        end
      end else if (pop) begin
        out0   <= out1;
        valid0 <= valid1;
        valid1 <= 1'b0;
      end else if (accept) begin
        if (!valid0) begin
          out0   <= res;
          valid0 <= 1'b1;
        end else begin
          out1   <= res;
          valid1 <= 1'b1;
        end
      end
    end
  end

  `OWBM_ASSERT(a_idle_timer_clear, clk, rst, (phase == PH_IDLE) |-> (tick_count == '0))
  `OWBM_ASSERT(a_timer_counts_down, clk, rst, (accept && phase != PH_IDLE && tick_count != '0) |=> (tick_count == $past(tick_count) - TIMER_BITS'(1) && phase == $past(phase)))
  `OWBM_ASSERT(a_done_implies_busy, clk, rst, (accept && res.done_res) |-> res.busy_res)
  `OWBM_ASSERT(a_buffer_fills, clk, rst, (accept && !pop && valid0) |=> valid1)
  `OWBM_ASSERT_ALWAYS(a_buffer_order, clk, valid1 |-> valid0)

endmodule

// ===== verif/one_wire_bus_master_unit_tb.sv =====
// Self-checking testbench for one_wire_bus_master_unit: directed stimulus table, then
// random command sequences under short random timing settings, with a tick-level bus
// predictor. Depends on owbm_pkg and the RTL of the unit only.
module one_wire_bus_master_unit_tb;
  import owbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TOTAL_TICKS = 500;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_REC,
    SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REST
  } seq_phase_e;

  typedef enum logic [1:0] {ROW_TICK, ROW_SET_ZERO, ROW_SET_TIGHT} row_kind_e;
  typedef enum logic [1:0] {FILL_LOW, FILL_HIGH, FILL_RAND} fill_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       cmd;
    logic [1:0] op;
    logic [7:0] wb;
    logic       line;
    fill_e      fill;
    logic       run_out;
    logic       has_exp;
    result_t    exp;
  } row_t;

  localparam result_t RES_QUIET = '0;
  localparam result_t RES_START = '{presence: 1'b0, read_byte: 8'h00, done_res: 1'b0,
                                    busy_res: 1'b1, drive_low: 1'b1};

  localparam int PLAN_LEN = 17;
  localparam row_t PLAN [PLAN_LEN] = '{
    // straight after reset, default timings: idle ticks only
    '{ROW_TICK, 1'b0, OP_RESET,  8'h00, 1'b0, FILL_RAND, 1'b0, 1'b1, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_UNUSED, 8'hFF, 1'b1, FILL_RAND, 1'b0, 1'b1, RES_QUIET},
    '{ROW_TICK, 1'b0, OP_READ,   8'h55, 1'b1, FILL_RAND, 1'b0, 1'b1, RES_QUIET},
    // every timing at zero: each phase still lasts one tick
    '{ROW_SET_ZERO, 1'b0, OP_RESET, 8'h00, 1'b0, FILL_RAND, 1'b0, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_RESET,  8'hFF, 1'b1, FILL_LOW,  1'b1, 1'b1, RES_START},
    '{ROW_TICK, 1'b1, OP_RESET,  8'h00, 1'b0, FILL_HIGH, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_WRITE,  8'h00, 1'b0, FILL_RAND, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_WRITE,  8'hFF, 1'b1, FILL_RAND, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_READ,   8'h00, 1'b1, FILL_HIGH, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_READ,   8'hFF, 1'b0, FILL_LOW,  1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_WRITE,  8'hA5, 1'b1, FILL_RAND, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_READ,   8'h5A, 1'b0, FILL_RAND, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_UNUSED, 8'h00, 1'b0, FILL_RAND, 1'b0, 1'b0, RES_QUIET},
    // write-zero low and read low plus sample longer than the slot: slot rests collapse to one tick
    '{ROW_SET_TIGHT, 1'b0, OP_RESET, 8'h00, 1'b0, FILL_RAND, 1'b0, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_RESET,  8'h00, 1'b1, FILL_LOW,  1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_WRITE,  8'h3C, 1'b0, FILL_RAND, 1'b1, 1'b0, RES_QUIET},
    '{ROW_TICK, 1'b1, OP_READ,   8'hC3, 1'b1, FILL_HIGH, 1'b1, 1'b0, RES_QUIET}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  one_wire_bus_master_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // bus sequencer mirror
  logic [CFG_DATA_W-1:0] timing_reg [8];
  logic [CFG_DATA_W-1:0] new_timing [8];
  seq_phase_e seq_phase;
  int         tick_left;
  logic [2:0] bit_pos;
  logic [7:0] shift_reg;
  logic       presence_seen;
  logic [7:0] last_read;

  result_t tick_results [$];
  int      mismatches = 0;
  int      words_checked = 0;
  int      cmds_started = 0;
  int      ticks_sent = 0;
  int      settings_used = 0;
  int      sender_burst = 0;

  function automatic int phase_len(seq_phase_e p);
    int low_t;
    int slot;
    slot = int'(timing_reg[REG_WRITE_SLOT]);
    low_t = shift_reg[bit_pos] ? int'(timing_reg[REG_WRITE_ONE_LOW])
                               : int'(timing_reg[REG_WRITE_ZERO_LOW]);
    case (p)
      SEQ_RST_LOW:  return int'(timing_reg[REG_RESET_LOW]);
      SEQ_RST_WAIT: return int'(timing_reg[REG_PRESENCE_WAIT]);
      SEQ_RST_REC:  return int'(timing_reg[REG_RESET_RECOVERY]);
      SEQ_WR_LOW:   return low_t;
      SEQ_WR_HIGH:  return slot > low_t ? slot - low_t : 0;
      SEQ_RD_LOW:   return int'(timing_reg[REG_READ_LOW]);
      SEQ_RD_WAIT:  return int'(timing_reg[REG_READ_SAMPLE]);
      SEQ_RD_REST: begin
        low_t = int'(timing_reg[REG_READ_LOW]) + int'(timing_reg[REG_READ_SAMPLE]);
        return slot > low_t ? slot - low_t : 0;
      end
      default:      return 0;
    endcase
  endfunction

  function automatic void load_phase(seq_phase_e p);
    int len;
    len = phase_len(p);
    tick_left = len == 0 ? 0 : len - 1;
    if (tick_left > TIMER_MAX) tick_left = TIMER_MAX;
    seq_phase = p;
  endfunction

  // one microsecond tick of the master
  function automatic result_t step_bus(logic cmd, logic [1:0] op, logic [7:0] wb, logic line);
    result_t r;
    r = '0;
    if (seq_phase == SEQ_IDLE && cmd && op != OP_UNUSED) begin
      bit_pos = '0;
      shift_reg = (op == OP_WRITE) ? wb : 8'h00;
      if (op == OP_RESET) load_phase(SEQ_RST_LOW);
      else if (op == OP_WRITE) load_phase(SEQ_WR_LOW);
      else load_phase(SEQ_RD_LOW);
    end
    if (seq_phase != SEQ_IDLE) begin
      r.busy_res = 1'b1;
      r.drive_low = (seq_phase == SEQ_RST_LOW || seq_phase == SEQ_WR_LOW ||
                     seq_phase == SEQ_RD_LOW);
      if (tick_left > 0) begin
        tick_left--;
      end else begin
        case (seq_phase)
          SEQ_RST_LOW: load_phase(SEQ_RST_WAIT);
          SEQ_RST_WAIT: begin
            presence_seen = ~line;
            load_phase(SEQ_RST_REC);
          end
          SEQ_RST_REC: begin
            r.done_res = 1'b1;
            seq_phase = SEQ_IDLE;
          end
          SEQ_WR_LOW: load_phase(SEQ_WR_HIGH);
          SEQ_WR_HIGH: begin
            if (bit_pos == 3'd7) begin
              r.done_res = 1'b1;
              seq_phase = SEQ_IDLE;
            end else begin
              bit_pos++;
              load_phase(SEQ_WR_LOW);
            end
          end
          SEQ_RD_LOW: load_phase(SEQ_RD_WAIT);
          SEQ_RD_WAIT: begin
            if (line) shift_reg[bit_pos] = 1'b1;
            load_phase(SEQ_RD_REST);
          end
          SEQ_RD_REST: begin
            if (bit_pos == 3'd7) begin
              last_read = shift_reg;
              r.done_res = 1'b1;
              seq_phase = SEQ_IDLE;
            end else begin
              bit_pos++;
              load_phase(SEQ_RD_LOW);
            end
          end
          default: seq_phase = SEQ_IDLE;
        endcase
      end
    end
    r.read_byte = last_read;
    r.presence = presence_seen;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_tick(input logic cmd, input logic [1:0] op, input logic [7:0] wb,
                           input logic line, input logic use_typed, input result_t typed);
    result_t r;
    int gap;
    int pick;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-9){1'b0}}, line, wb};
    s_axis_tuser  <= {op, cmd};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    if (seq_phase == SEQ_IDLE && cmd && op != OP_UNUSED) cmds_started++;
    r = step_bus(cmd, op, wb, line);
    tick_results.push_back(use_typed ? typed : r);
    ticks_sent++;
    gap = 0;
    if (sender_burst > 0) begin
      sender_burst--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) sender_burst = $urandom_range(30, 150);
      else if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // keep ticking until the running command has finished; commands offered meanwhile
  // must be ignored
  task automatic run_out(input fill_e fill);
    logic line;
    while (seq_phase != SEQ_IDLE) begin
      case (fill)
        FILL_LOW:  line = 1'b0;
        FILL_HIGH: line = 1'b1;
        default:   line = 1'($urandom_range(0, 1));
      endcase
      send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), line, 1'b0, RES_QUIET);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    // results pass through the output buffer before they leave
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_timing();
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= new_timing[i];
      @(posedge clk);
      // slot timings keep only their low bits
      if (i < int'(REG_WRITE_ONE_LOW)) timing_reg[i] = new_timing[i];
      else timing_reg[i] = CFG_DATA_W'(new_timing[i][SLOT_W-1:0]);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_W-1:0];
      if (tick_results.size() == 0) begin
        note_failure($sformatf("result word with none expected: %03h", got));
      end else begin
        want = tick_results.pop_front();
        words_checked++;
        if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res || got.read_byte !== want.read_byte ||
            got.presence !== want.presence)
          note_failure($sformatf(
            "word %0d exp drv=%0b busy=%0b done=%0b byte=%02h pres=%0b got %0b %0b %0b %02h %0b",
            words_checked, want.drive_low, want.busy_res, want.done_res, want.read_byte,
            want.presence, got.drive_low, got.busy_res, got.done_res, got.read_byte,
            got.presence));
      end
    end
  end

  // receiver: random stalls, stretches of steady readiness and long hold-offs
  initial begin : receiver
    int rx_cycles;
    int hold_left;
    logic hold_level;
    int pick;
    rx_cycles = 0;
    hold_left = 0;
    hold_level = 1'b1;
    forever begin
      @(posedge clk);
      rx_cycles++;
      // early enough to land while the directed commands are still streaming
      if (rx_cycles == 200) begin
        hold_level = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        m_axis_tready <= hold_level;
        hold_left--;
      end else begin
        pick = $urandom_range(0, 999);
        if (pick < 3) begin
          hold_level = 1'b0;
          hold_left = $urandom_range(100, 300);
          m_axis_tready <= 1'b0;
        end else if (pick < 40) begin
          hold_level = 1'b1;
          hold_left = $urandom_range(50, 300);
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int n_cmds;
    int waited;
    timing_reg[REG_RESET_LOW]      = 10'd500;
    timing_reg[REG_PRESENCE_WAIT]  = 10'd80;
    timing_reg[REG_RESET_RECOVERY] = 10'd300;
    timing_reg[REG_WRITE_ONE_LOW]  = 10'd5;
    timing_reg[REG_WRITE_ZERO_LOW] = 10'd62;
    timing_reg[REG_WRITE_SLOT]     = 10'd65;
    timing_reg[REG_READ_LOW]       = 10'd4;
    timing_reg[REG_READ_SAMPLE]    = 10'd9;
    seq_phase = SEQ_IDLE;
    tick_left = 0;
    bit_pos = '0;
    shift_reg = '0;
    presence_seen = 1'b0;
    last_read = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      case (PLAN[i].kind)
        ROW_SET_ZERO: begin
          for (int k = 0; k < 8; k++) new_timing[k] = '0;
          apply_timing();
        end
        ROW_SET_TIGHT: begin
          new_timing[REG_RESET_LOW]      = 10'd2;
          new_timing[REG_PRESENCE_WAIT]  = 10'd3;
          new_timing[REG_RESET_RECOVERY] = 10'd2;
          new_timing[REG_WRITE_ONE_LOW]  = 10'd3;
          new_timing[REG_WRITE_ZERO_LOW] = 10'd6;
          new_timing[REG_WRITE_SLOT]     = 10'd4;
          new_timing[REG_READ_LOW]       = 10'd3;
          new_timing[REG_READ_SAMPLE]    = 10'd2;
          apply_timing();
        end
        default: begin
          send_tick(PLAN[i].cmd, PLAN[i].op, PLAN[i].wb, PLAN[i].line,
                    PLAN[i].has_exp, PLAN[i].exp);
          if (PLAN[i].run_out) run_out(PLAN[i].fill);
        end
      endcase
    end

    while (ticks_sent < TOTAL_TICKS) begin
      new_timing[REG_RESET_LOW]      = CFG_DATA_W'($urandom_range(0, 5));
      new_timing[REG_PRESENCE_WAIT]  = CFG_DATA_W'($urandom_range(0, 5));
      new_timing[REG_RESET_RECOVERY] = CFG_DATA_W'($urandom_range(0, 5));
      new_timing[REG_WRITE_ONE_LOW]  = CFG_DATA_W'($urandom_range(0, 4));
      new_timing[REG_WRITE_ZERO_LOW] = CFG_DATA_W'($urandom_range(0, 8));
      new_timing[REG_WRITE_SLOT]     = CFG_DATA_W'($urandom_range(0, 12));
      new_timing[REG_READ_LOW]       = CFG_DATA_W'($urandom_range(0, 4));
      new_timing[REG_READ_SAMPLE]    = CFG_DATA_W'($urandom_range(0, 5));
      apply_timing();
      n_cmds = $urandom_range(2, 5);
      repeat (n_cmds) begin
        // idle ticks, some with the unused opcode offered
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 1))
            send_tick(1'b1, OP_UNUSED, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, RES_QUIET);
          else
            send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, RES_QUIET);
        end
        send_tick(1'b1, 2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, RES_QUIET);
        case ($urandom_range(0, 9))
          0:       run_out(FILL_LOW);
          1:       run_out(FILL_HIGH);
          default: run_out(FILL_RAND);
        endcase
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (tick_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (tick_results.size() != 0)
      note_failure($sformatf("%0d result words never arrived", tick_results.size()));

    $display("%0d commands over %0d ticks under %0d timing settings (zero, tight, random)",
             cmds_started, ticks_sent, settings_used);
    $display("%0d result words checked, %0d failures", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
